[src/dfac_pkg.sv]
package dfac_pkg;

    localparam int GUARD_TICKS = 4;
    localparam logic [2:0] LAG_TICKS = 3'd4;
    localparam logic [9:0] DWELL_MAX = 10'd1023;

    typedef enum logic [1:0] {
        MODE_RUN     = 2'd0,
        MODE_TEST    = 2'd1,
        MODE_STANDBY = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_HEAT_ON  = 2'd0,
        REG_HEAT_OFF = 2'd1,
        REG_COOL_ON  = 2'd2,
        REG_COOL_OFF = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic       warmup_active;
        logic       memory_error;
        logic       powerup_hold;
        logic [1:0] mode;
        logic       freeze_only;
        logic       defrost_active;
        logic       valve_init_done;
        logic       cooling_request;
        logic       heating_active;
        logic       fan1_delay_active;
        logic       fan1_delay_running;
    } in_t;

    typedef struct packed {
        logic       fan1_on;
        logic       fan2_on;
        logic       fan1_lag_write;
        logic [2:0] fan1_lag_value;
        logic       fan2_lag_write;
        logic [2:0] fan2_lag_value;
        logic       delay_done;
    } out_t;

    typedef struct packed {
        logic [7:0] heat_on_time;
        logic [7:0] heat_off_time;
        logic [7:0] cool_on_time;
        logic [7:0] cool_off_time;
    } cfg_t;

    typedef struct packed {
        logic       fan1_drive;
        logic       fan2_drive;
        logic       fan1_phase_on;
        logic       fan2_phase_on;
        logic [9:0] dwell_count;
        logic       cooling_at_delay_end;
    } state_t;

endpackage

[src/dfac_core.sv]
module dfac_core
    import dfac_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 4
)
(
    input  in_t    item,
    input  cfg_t   cfg,
    input  state_t cur,
    output state_t nxt,
    output out_t   result
);

    localparam int RAW_W  = 8 + $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = (RAW_W > 10) ? RAW_W : 10;

    function automatic logic [9:0] to_ticks(input logic [7:0] secs);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(secs) * PROD_W'(TICKS_PER_SECOND);
        if (prod > PROD_W'(DWELL_MAX))
        begin
            return DWELL_MAX;
        end
        return prod[9:0];
    endfunction

    logic       ignored;
    logic       do_dwell;
    logic [9:0] on_t;
    logic [9:0] off_t;
    logic [9:0] dec;
    logic       guard;

    always_comb
    begin
        nxt      = cur;
        result   = '0;
        do_dwell = 1'b0;
        on_t     = to_ticks(cfg.heat_on_time);
        off_t    = to_ticks(cfg.heat_off_time);
        dec      = '0;
        guard    = 1'b0;
        ignored  = item.warmup_active || item.memory_error || item.powerup_hold
                   || (item.mode == MODE_TEST);

        if (!ignored)
        begin
            case (item.mode)
                MODE_STANDBY:
                begin
                    nxt.fan1_drive = 1'b0;
                    nxt.fan2_drive = 1'b0;
                end
                MODE_RUN:
                begin
                    if (item.defrost_active)
                    begin
                        nxt.fan1_drive     = 1'b0;
                        nxt.fan2_drive     = 1'b0;
                        nxt.fan1_phase_on  = 1'b0;
                        nxt.fan2_phase_on  = 1'b0;
                        result.fan1_lag_write = 1'b1;
                        result.fan2_lag_write = 1'b1;
                    end
                    else if (item.freeze_only)
                    begin
                        if (item.valve_init_done)
                        begin
                            if (item.cooling_request)
                            begin
                                if (!cur.fan2_drive)
                                begin
                                    result.fan2_lag_write = 1'b1;
                                    if (!cur.fan1_phase_on)
                                    begin
                                        nxt.fan1_drive    = 1'b1;
                                        nxt.fan1_phase_on = 1'b1;
                                    end
                                end
                                else
                                begin
                                    nxt.fan2_drive        = 1'b0;
                                    nxt.fan1_phase_on     = 1'b1;
                                    nxt.fan2_phase_on     = 1'b0;
                                    result.fan1_lag_write = 1'b1;
                                    result.fan1_lag_value = LAG_TICKS;
                                end
                            end
                            else
                            begin
                                if (!cur.fan1_drive)
                                begin
                                    result.fan1_lag_write = 1'b1;
                                    if (!cur.fan2_phase_on)
                                    begin
                                        nxt.fan2_drive    = 1'b1;
                                        nxt.fan2_phase_on = 1'b1;
                                    end
                                end
                                else
                                begin
                                    nxt.fan1_drive        = 1'b0;
                                    nxt.fan2_phase_on     = 1'b1;
                                    nxt.fan1_phase_on     = 1'b0;
                                    result.fan2_lag_write = 1'b1;
                                    result.fan2_lag_value = LAG_TICKS;
                                end
                            end
                        end
                    end
                    else if (item.heating_active)
                    begin
                        do_dwell = 1'b1;
                    end
                    else if (item.fan1_delay_active)
                    begin
                        if (item.fan1_delay_running)
                        begin
                            nxt.fan1_drive    = 1'b1;
                            nxt.fan2_drive    = 1'b0;
                            nxt.fan1_phase_on = 1'b1;
                            nxt.fan2_phase_on = 1'b0;
                        end
                        else
                        begin
                            nxt.fan1_drive    = 1'b0;
                            nxt.fan2_drive    = 1'b0;
                            nxt.fan1_phase_on = 1'b0;
                            nxt.fan2_phase_on = 1'b0;
                            if (item.valve_init_done)
                            begin
                                nxt.cooling_at_delay_end = item.cooling_request;
                            end
                            result.delay_done = 1'b1;
                            nxt.dwell_count   = 10'd1;
                        end
                    end
                    else
                    begin
                        nxt.fan1_phase_on = cur.cooling_at_delay_end;
                        if (item.valve_init_done && item.cooling_request)
                        begin
                            do_dwell = 1'b1;
                            on_t     = to_ticks(cfg.cool_on_time);
                            off_t    = to_ticks(cfg.cool_off_time);
                        end
                        else
                        begin
                            nxt.fan1_drive    = 1'b0;
                            nxt.fan2_drive    = 1'b0;
                            nxt.fan1_phase_on = 1'b0;
                            nxt.fan2_phase_on = 1'b0;
                            nxt.dwell_count   = 10'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_dwell && (nxt.dwell_count != 10'd0))
        begin
            dec             = nxt.dwell_count - 10'd1;
            nxt.dwell_count = dec;
            if (dec == 10'd0)
            begin
                if (!nxt.fan1_phase_on)
                begin
                    if (on_t != 10'd0)
                    begin
                        nxt.dwell_count   = on_t;
                        nxt.fan1_phase_on = 1'b1;
                        nxt.fan1_drive    = !nxt.fan2_phase_on;
                    end
                    else if (off_t != 10'd0)
                    begin
                        nxt.dwell_count   = off_t;
                        nxt.fan1_phase_on = 1'b0;
                        nxt.fan1_drive    = 1'b0;
                    end
                    else
                    begin
                        nxt.fan1_drive    = 1'b0;
                        nxt.fan2_drive    = 1'b0;
                        nxt.fan1_phase_on = 1'b0;
                        nxt.fan2_phase_on = 1'b0;
                        nxt.dwell_count   = 10'd1;
                    end
                end
                else if (off_t != 10'd0)
                begin
                    nxt.dwell_count   = off_t;
                    nxt.fan1_phase_on = 1'b0;
                    nxt.fan1_drive    = 1'b0;
                end
                else
                begin
                    nxt.dwell_count   = on_t;
                    nxt.fan1_phase_on = 1'b1;
                    nxt.fan1_drive    = 1'b1;
                end
            end
            else if (!nxt.fan1_phase_on)
            begin
                guard = ({1'b0, dec} + 11'(GUARD_TICKS)) >= {1'b0, off_t};
                nxt.fan2_drive    = !guard;
                nxt.fan2_phase_on = !guard;
            end
            else
            begin
                nxt.fan2_drive = 1'b0;
                if (nxt.fan2_phase_on)
                begin
                    guard = ({1'b0, dec} + 11'(GUARD_TICKS)) >= {1'b0, on_t};
                    nxt.fan1_drive    = !guard;
                    nxt.fan1_phase_on = !guard;
                end
            end
        end

        result.fan1_on = nxt.fan1_drive;
        result.fan2_on = nxt.fan2_drive;
    end

endmodule

[src/dual_fan_alternation_controller_unit.sv]
// Dual fan controller taking one 250 ms tick request per clock cycle. A
// request is captured in an input register, settled in a single pass of
// logic against the fan state and the configured dwell times, and its result
// is held in an output register; a new request is taken every cycle while
// the output side keeps up. The dwell time registers should only be written
// while no request is in flight.
module dual_fan_alternation_controller_unit
    import dfac_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic   in_valid_reg;
    in_t    in_reg;
    logic   out_valid_reg;
    out_t   out_reg;
    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   result;
    logic   advance;
    logic   in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    dfac_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_core (
        .item   (in_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_HEAT_ON:  cfg_reg.heat_on_time  <= cfg_data;
                    REG_HEAT_OFF: cfg_reg.heat_off_time <= cfg_data;
                    REG_COOL_ON:  cfg_reg.cool_on_time  <= cfg_data;
                    REG_COOL_OFF: cfg_reg.cool_off_time <= cfg_data;
                    default:      cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A lag value is only ever reported alongside its write strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.fan1_lag_value == 3'd0) || out_reg.fan1_lag_write))
        else $error("FAN1 lag value without write strobe");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.fan2_lag_value == 3'd0) || out_reg.fan2_lag_write))
        else $error("FAN2 lag value without write strobe");

    // Clearing the post-heating delay always leaves both fans off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.delay_done) |-> (!out_reg.fan1_on && !out_reg.fan2_on))
        else $error("Delay cleared with a fan still driven");

    // A request moved into the output stage is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Processed request lost before output");

    // The output register is never overwritten while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("Stalled result overwritten");

endmodule
